### rtl/kvlp_pkg.sv
// Shared types, codes and character-class helpers for the key/value line parser.
// No dependencies.
package kvlp_pkg;

  localparam int LINE_LEN_DEF  = 256;
  localparam int KEY_LEN_DEF   = 64;
  localparam int VALUE_LEN_DEF = 256;

  localparam int CHAR_W = 8;
  localparam int STAT_W = 3;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_DQ    = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQ    = 8'h27;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'hFF;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 3'd0,
    ST_ABORT  = 3'd1,
    ST_START  = 3'd2,
    ST_KEYWD  = 3'd3,
    ST_EQUAL  = 3'd4,
    ST_VSTART = 3'd5,
    ST_QUOTE  = 3'd6,
    ST_VALUE  = 3'd7
  } status_t;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_KEYWD  = 6'b000010,
    PH_EQUAL  = 6'b000100,
    PH_VSTART = 6'b001000,
    PH_QUOTE  = 6'b010000,
    PH_VALUE  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic is_alpha;
    logic is_digit;
    logic is_space;
    logic is_print;
    logic is_term;
    logic is_eq;
    logic is_hash;
    logic is_under;
    logic is_dq;
    logic is_sq;
  } cls_t;

  typedef struct packed {
    phase_t  phase;
    logic    locked;
    status_t locked_code;
    logic    quote_dbl;
  } pstate_t;

  typedef struct packed {
    logic              key_vld;
    logic              val_vld;
    logic [CHAR_W-1:0] ch;
    logic              line_end;
    status_t           status;
  } res_t;

  function automatic status_t phase_status(input phase_t ph);
    status_t s;
    unique case (ph)
      PH_START:  s = ST_START;
      PH_KEYWD:  s = ST_KEYWD;
      PH_EQUAL:  s = ST_EQUAL;
      PH_VSTART: s = ST_VSTART;
      PH_QUOTE:  s = ST_QUOTE;
      PH_VALUE:  s = ST_VALUE;
      default:   s = ST_ABORT;
    endcase
    return s;
  endfunction

  localparam pstate_t PSTATE_RST = '{phase: PH_START, locked: 1'b0,
                                     locked_code: ST_DONE, quote_dbl: 1'b0};

endpackage

### rtl/kvlp_classify.sv
// Character classifier: C-locale classes for 7-bit bytes, none for 0x80-0xFE.
// Depends on kvlp_pkg.
module kvlp_classify (
  input  logic [kvlp_pkg::CHAR_W-1:0] ch,
  output kvlp_pkg::cls_t              cls
);
  import kvlp_pkg::*;

  always_comb begin
    cls.is_alpha = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
    cls.is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    cls.is_space = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    cls.is_print = (ch >= 8'h20) && (ch <= 8'h7E);
    cls.is_term  = (ch == CH_NL) || (ch == CH_NUL) || (ch == CH_FF);
    cls.is_eq    = (ch == CH_EQ);
    cls.is_hash  = (ch == CH_HASH);
    cls.is_under = (ch == CH_UNDER);
    cls.is_dq    = (ch == CH_DQ);
    cls.is_sq    = (ch == CH_SQ);
  end

endmodule

### rtl/kvlp_step.sv
// Per-character parse step: next parser state, counters and result item.
// Depends on kvlp_pkg and kvlp_classify.
module kvlp_step #(
  parameter int LINE_LEN  = kvlp_pkg::LINE_LEN_DEF,
  parameter int KEY_LEN   = kvlp_pkg::KEY_LEN_DEF,
  parameter int VALUE_LEN = kvlp_pkg::VALUE_LEN_DEF,
  localparam int LW = $clog2(LINE_LEN),
  localparam int KW = $clog2(KEY_LEN),
  localparam int VW = $clog2(VALUE_LEN)
) (
  input  logic [kvlp_pkg::CHAR_W-1:0] ch,
  input  kvlp_pkg::pstate_t           st,
  input  logic [KW-1:0]               key_cnt,
  input  logic [VW-1:0]               val_cnt,
  input  logic [LW-1:0]               line_cnt,
  output kvlp_pkg::pstate_t           st_nxt,
  output logic [KW-1:0]               key_cnt_nxt,
  output logic [VW-1:0]               val_cnt_nxt,
  output logic [LW-1:0]               line_cnt_nxt,
  output kvlp_pkg::res_t              res
);
  import kvlp_pkg::*;

  cls_t        cls;
  pstate_t     s;
  logic [KW-1:0] kc;
  logic [VW-1:0] vc;
  logic [LW-1:0] line_inc;
  logic        kv;
  logic        vv;
  logic        key_full;
  logic        val_full;
  logic        qmatch;
  logic        line_end;

  kvlp_classify u_cls (
    .ch  (ch),
    .cls (cls)
  );

  assign line_inc = line_cnt + LW'(1);
  assign key_full = (key_cnt >= KW'(KEY_LEN - 1));
  assign val_full = (val_cnt >= VW'(VALUE_LEN - 1));
  assign qmatch   = st.quote_dbl ? cls.is_dq : cls.is_sq;

  always_comb begin
    s  = st;
    kc = key_cnt;
    vc = val_cnt;
    kv = 1'b0;
    vv = 1'b0;
    if (!cls.is_term && !st.locked) begin
      unique case (st.phase)
        PH_START: begin
          if (cls.is_alpha || cls.is_under) begin
            kv = 1'b1;
            kc = key_cnt + KW'(1);
            s.phase = PH_KEYWD;
          end else if (!cls.is_space) begin
            s.locked = 1'b1;
            s.locked_code = ST_START;
          end
        end
        PH_KEYWD: begin
          priority if (cls.is_space) begin
            s.phase = PH_EQUAL;
          end else if (cls.is_eq) begin
            s.phase = PH_VSTART;
          end else if (cls.is_alpha || cls.is_digit || cls.is_under) begin
            if (key_full) begin
              s.locked = 1'b1;
              s.locked_code = ST_ABORT;
            end else begin
              kv = 1'b1;
              kc = key_cnt + KW'(1);
            end
          end else begin
            s.locked = 1'b1;
            s.locked_code = ST_KEYWD;
          end
        end
        PH_EQUAL: begin
          if (!cls.is_space) begin
            if (cls.is_eq) begin
              s.phase = PH_VSTART;
            end else begin
              s.locked = 1'b1;
              s.locked_code = ST_EQUAL;
            end
          end
        end
        PH_VSTART: begin
          if (!cls.is_space) begin
            priority if (cls.is_dq || cls.is_sq) begin
              s.quote_dbl = cls.is_dq;
              s.phase = PH_QUOTE;
            end else if (cls.is_hash || !cls.is_print) begin
              s.locked = 1'b1;
              s.locked_code = ST_VSTART;
            end else begin
              vv = 1'b1;
              vc = val_cnt + VW'(1);
              s.phase = PH_VALUE;
            end
          end
        end
        PH_QUOTE: begin
          priority if (qmatch) begin
            s.locked = 1'b1;
            s.locked_code = ST_DONE;
          end else if (val_full) begin
            s.locked = 1'b1;
            s.locked_code = ST_ABORT;
          end else begin
            vv = 1'b1;
            vc = val_cnt + VW'(1);
          end
        end
        PH_VALUE: begin
          if (cls.is_print && !cls.is_hash) begin
            if (val_full) begin
              s.locked = 1'b1;
              s.locked_code = ST_ABORT;
            end else begin
              vv = 1'b1;
              vc = val_cnt + VW'(1);
            end
          end else begin
            s.locked = 1'b1;
            s.locked_code = ST_DONE;
          end
        end
        default: begin
          s.locked = 1'b1;
          s.locked_code = ST_ABORT;
        end
      endcase
    end
  end

  assign line_end = cls.is_term || (line_inc >= LW'(LINE_LEN - 1));

  always_comb begin
    res.key_vld  = kv;
    res.val_vld  = vv;
    res.ch       = (kv || vv) ? ch : '0;
    res.line_end = line_end;
    res.status   = ST_DONE;
    if (line_end) begin
      priority if (s.locked) begin
        res.status = s.locked_code;
      end else if (s.phase == PH_VALUE) begin
        res.status = ST_DONE;
      end else begin
        res.status = phase_status(s.phase);
      end
    end
    if (line_end) begin
      st_nxt       = PSTATE_RST;
      key_cnt_nxt  = '0;
      val_cnt_nxt  = '0;
      line_cnt_nxt = '0;
    end else begin
      st_nxt       = s;
      key_cnt_nxt  = kc;
      val_cnt_nxt  = vc;
      line_cnt_nxt = line_inc;
    end
  end

endmodule

### rtl/key_value_line_parser.sv
// Key/value line parser top level: parser state registers and result register.
// Depends on kvlp_pkg and kvlp_step.
//
// Takes one ASCII byte per item and tokenises lines of the form
// KEYWORD = VALUE # COMMENT. Every byte gives one result item in the cycle after
// it is accepted; a new byte is accepted in every cycle while the result
// register is empty or being drained, so the sustained rate is one item per
// cycle, set by the single parse step between the state registers and the
// result register. out_tlast marks the byte that ends a line (newline, NUL,
// 0xFF, or the LINE_LEN-1th byte); out_tdata[10:8] then carries the outcome:
// 0 done, 1 abort, 2 start, 3 keyword, 4 equal, 5 value start, 6 quote, 7 value.
module key_value_line_parser #(
  parameter int LINE_LEN  = kvlp_pkg::LINE_LEN_DEF,
  parameter int KEY_LEN   = kvlp_pkg::KEY_LEN_DEF,
  parameter int VALUE_LEN = kvlp_pkg::VALUE_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [kvlp_pkg::CHAR_W-1:0]      in_tdata,   // [7:0] ch
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kvlp_pkg::OUT_DATA_W-1:0]  out_tdata,  // [7:0] out_char, [10:8] status, rest 0
  output logic [kvlp_pkg::OUT_USER_W-1:0]  out_tuser,  // [0] key_char_valid, [1] value_char_valid
  output logic                             out_tlast   // line_end
);
  import kvlp_pkg::*;

  localparam int LW = $clog2(LINE_LEN);
  localparam int KW = $clog2(KEY_LEN);
  localparam int VW = $clog2(VALUE_LEN);

  pstate_t       st_r, st_nxt;
  logic [KW-1:0] key_cnt_r, key_cnt_nxt;
  logic [VW-1:0] val_cnt_r, val_cnt_nxt;
  logic [LW-1:0] line_cnt_r, line_cnt_nxt;
  res_t          res_nxt, res_r;
  logic          out_vld_r;
  logic          in_acc;

  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  kvlp_step #(
    .LINE_LEN  (LINE_LEN),
    .KEY_LEN   (KEY_LEN),
    .VALUE_LEN (VALUE_LEN)
  ) u_step (
    .ch           (in_tdata),
    .st           (st_r),
    .key_cnt      (key_cnt_r),
    .val_cnt      (val_cnt_r),
    .line_cnt     (line_cnt_r),
    .st_nxt       (st_nxt),
    .key_cnt_nxt  (key_cnt_nxt),
    .val_cnt_nxt  (val_cnt_nxt),
    .line_cnt_nxt (line_cnt_nxt),
    .res          (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= PSTATE_RST;
      key_cnt_r  <= '0;
      val_cnt_r  <= '0;
      line_cnt_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r       <= st_nxt;
        key_cnt_r  <= key_cnt_nxt;
        val_cnt_r  <= val_cnt_nxt;
        line_cnt_r <= line_cnt_nxt;
        out_vld_r  <= 1'b1;
      end else if (out_tready) begin
        out_vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - CHAR_W - STAT_W){1'b0}}, res_r.status, res_r.ch};
  assign out_tuser  = {res_r.val_vld, res_r.key_vld};
  assign out_tlast  = res_r.line_end;

  a_kv_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.key_vld && res_r.val_vld))
    else $error("key and value flags both set");

  a_status_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.line_end |-> res_r.status == ST_DONE)
    else $error("status set away from line end");

  a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_nxt.line_end |=> st_r.phase == PH_START && !st_r.locked
      && line_cnt_r == '0 && key_cnt_r == '0 && val_cnt_r == '0)
    else $error("state not cleared after line end");

  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r.phase))
    else $error("phase not one-hot");

  a_key_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_cnt_r <= KW'(KEY_LEN - 1) && val_cnt_r <= VW'(VALUE_LEN - 1))
    else $error("count beyond its limit");

endmodule

### tb/sv/tb_key_value_line_parser.sv
// Testbench for key_value_line_parser: directed and random character lines
// are checked against a predictor of the line tokeniser, with random stalls.
// Depends on kvlp_pkg and the key_value_line_parser RTL.
module tb_key_value_line_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import kvlp_pkg::*;

  localparam int LINE_LEN    = LINE_LEN_DEF;
  localparam int KEY_LEN     = KEY_LEN_DEF;
  localparam int VALUE_LEN   = VALUE_LEN_DEF;
  localparam int RANDOM_ITEMS = 750;
  localparam int HOLD_LEN    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int WDOG_LIMIT  = 5000;
  localparam int MAX_REPORTS = 40;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CHAR_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // [7:0] out_char, [10:8] status, rest 0
  logic [OUT_USER_W-1:0] out_tuser;  // [0] key_char_valid, [1] value_char_valid
  logic                  out_tlast;

  // tokeniser state of the predictor
  status_t kv_phase = ST_START;
  bit      kv_locked = 1'b0;
  status_t kv_outcome = ST_DONE;
  bit      kv_dquote = 1'b0;
  int      key_n = 0;
  int      val_n = 0;
  int      line_n = 0;

  res_t        token_q[$];
  logic [7:0]  line_buf[$];
  int          errors = 0;
  int          items_sent = 0;
  bit          tx_fast = 1'b0;
  bit          rx_fast = 1'b0;
  bit          hold_req = 1'b0;
  int          rx_stall = 0;
  int          idle_cycles = 0;

  key_value_line_parser #(
    .LINE_LEN  (LINE_LEN),
    .KEY_LEN   (KEY_LEN),
    .VALUE_LEN (VALUE_LEN)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_visible(input logic [7:0] c);
    return c >= 8'h20 && c <= 8'h7E;
  endfunction

  function automatic void lock_outcome(input status_t s);
    kv_locked  = 1'b1;
    kv_outcome = s;
  endfunction

  function automatic void clear_line();
    kv_phase   = ST_START;
    kv_locked  = 1'b0;
    kv_outcome = ST_DONE;
    kv_dquote  = 1'b0;
    key_n      = 0;
    val_n      = 0;
    line_n     = 0;
  endfunction

  function automatic res_t tokenise_char(input logic [7:0] c);
    res_t r;
    r = '0;
    line_n++;
    if (c == CH_NL || c == CH_NUL || c == CH_FF) begin
      r.line_end = 1'b1;
    end else if (!kv_locked) begin
      case (kv_phase)
        ST_START: begin
          if (is_letter(c) || c == CH_UNDER) begin
            r.key_vld = 1'b1;
            key_n++;
            kv_phase = ST_KEYWD;
          end else if (!is_blank(c)) begin
            lock_outcome(ST_START);
          end
        end
        ST_KEYWD: begin
          if (is_blank(c)) begin
            kv_phase = ST_EQUAL;
          end else if (c == CH_EQ) begin
            kv_phase = ST_VSTART;
          end else if (is_letter(c) || is_numeral(c) || c == CH_UNDER) begin
            if (key_n >= KEY_LEN - 1) begin
              lock_outcome(ST_ABORT);
            end else begin
              r.key_vld = 1'b1;
              key_n++;
            end
          end else begin
            lock_outcome(ST_KEYWD);
          end
        end
        ST_EQUAL: begin
          if (c == CH_EQ) begin
            kv_phase = ST_VSTART;
          end else if (!is_blank(c)) begin
            lock_outcome(ST_EQUAL);
          end
        end
        ST_VSTART: begin
          if (!is_blank(c)) begin
            if (c == CH_DQ || c == CH_SQ) begin
              kv_dquote = (c == CH_DQ);
              kv_phase  = ST_QUOTE;
            end else if (c == CH_HASH || !is_visible(c)) begin
              lock_outcome(ST_VSTART);
            end else begin
              r.val_vld = 1'b1;
              val_n++;
              kv_phase = ST_VALUE;
            end
          end
        end
        ST_QUOTE: begin
          if (c == (kv_dquote ? CH_DQ : CH_SQ)) begin
            lock_outcome(ST_DONE);
          end else if (val_n >= VALUE_LEN - 1) begin
            lock_outcome(ST_ABORT);
          end else begin
            r.val_vld = 1'b1;
            val_n++;
          end
        end
        ST_VALUE: begin
          if (is_visible(c) && c != CH_HASH) begin
            if (val_n >= VALUE_LEN - 1) begin
              lock_outcome(ST_ABORT);
            end else begin
              r.val_vld = 1'b1;
              val_n++;
            end
          end else begin
            lock_outcome(ST_DONE);
          end
        end
        default: begin
          lock_outcome(kv_phase);
        end
      endcase
    end
    if (line_n >= LINE_LEN - 1) r.line_end = 1'b1;
    if (r.line_end) begin
      if (kv_locked) r.status = kv_outcome;
      else if (kv_phase == ST_VALUE) r.status = ST_DONE;
      else r.status = kv_phase;
      clear_line();
    end
    if (r.key_vld || r.val_vld) r.ch = c;
    return r;
  endfunction

  function automatic int tx_gap();
    int r;
    if (tx_fast) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom_range(0, 255));
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    token_q.push_back(tokenise_char(c));
    items_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  task automatic send_buf();
    foreach (line_buf[i]) send_char(line_buf[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (token_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: unexpected result, expected none, actual tdata %h tuser %b tlast %b",
                   $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = token_q.pop_front();
        check_field("key flag", 16'(want.key_vld), 16'(out_tuser[0]));
        check_field("value flag", 16'(want.val_vld), 16'(out_tuser[1]));
        check_field("char", 16'(want.ch), 16'(out_tdata[7:0]));
        check_field("status", 16'(want.status), 16'(out_tdata[10:8]));
        check_field("line end", 16'(want.line_end), 16'(out_tlast));
        check_field("tdata padding", 16'h0, 16'(out_tdata[15:11]));
      end
    end
  end

  always @(posedge clk) begin : rx_ready
    if (hold_req) begin
      hold_req = 1'b0;
      rx_stall = HOLD_LEN;
    end
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall--;
    end else if (!rx_fast && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      rx_stall = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_key_char(input bit head);
    int n;
    n = head ? $urandom_range(0, 52) : $urandom_range(0, 62);
    if (n < 26) return 8'("a" + n);
    if (n < 52) return 8'("A" + n - 26);
    if (n == 52) return CH_UNDER;
    return 8'("0" + n - 53);
  endfunction

  function automatic logic [7:0] rand_bare(input bit head);
    logic [7:0] c;
    do c = 8'($urandom_range(8'h20, 8'h7E));
    while (c == CH_HASH || (head && (c == " " || c == CH_DQ || c == CH_SQ)));
    return c;
  endfunction

  function automatic logic [7:0] rand_quoted(input logic [7:0] q);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 254)); while (c == q || c == CH_NL);
    return c;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 4))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0B;
      3: return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] rand_term();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return CH_NL;
    if (r < 90) return CH_NUL;
    return CH_FF;
  endfunction

  task automatic build_line(input bit broken);
    int n;
    int kind;
    logic [7:0] q;
    line_buf.delete();
    repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
    n = ($urandom_range(0, 99) < 5) ? $urandom_range(50, 70) : $urandom_range(1, 12);
    line_buf.push_back(rand_key_char(1'b1));
    repeat (n - 1) line_buf.push_back(rand_key_char(1'b0));
    repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
    line_buf.push_back(CH_EQ);
    repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
    n = ($urandom_range(0, 99) < 4) ? $urandom_range(150, 250) : $urandom_range(0, 15);
    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      line_buf.push_back(rand_bare(1'b1));
      repeat (n) line_buf.push_back(rand_bare(1'b0));
    end else begin
      q = (kind == 1) ? CH_SQ : CH_DQ;
      line_buf.push_back(q);
      repeat (n) line_buf.push_back(rand_quoted(q));
      if ($urandom_range(0, 9) != 0) line_buf.push_back(q);
    end
    if ($urandom_range(0, 1) == 1) begin
      repeat ($urandom_range(0, 2)) line_buf.push_back(rand_blank());
      line_buf.push_back(CH_HASH);
      repeat ($urandom_range(0, 10)) line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    if (broken) line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    line_buf.push_back(rand_term());
  endtask

  task automatic build_noise();
    line_buf.delete();
    repeat ($urandom_range(1, 30)) line_buf.push_back(8'($urandom_range(0, 255)));
    line_buf.push_back(rand_term());
  endtask

  task automatic test_empty_lines();
    send_char(CH_NL);
    send_char(CH_NUL);
    send_char(CH_FF);
    send_text("  a\n");
    send_text("b \n");
    send_text("c=");
    send_char(CH_FF);
    wait_drained();
  endtask

  task automatic test_values();
    send_text("Key_9 = bare v#c\n");
    send_text("_='it\"s'\n");
    send_text("x=\"a'#\"tail\n");
    send_text("y=ab\n");
    send_text("z = \"open\n");
    wait_drained();
  endtask

  task automatic test_early_outcomes();
    send_text("9k\n");
    send_text("k-\n");
    send_text("k x\n");
    send_text("k=#\n");
    send_text("k=");
    send_char(8'h80);
    send_char(CH_NL);
    send_text("k=a\tb\n");
    send_char(8'hFE);
    send_char(CH_NL);
    wait_drained();
  endtask

  task automatic test_key_overflow();
    line_buf.delete();
    repeat (KEY_LEN - 1) line_buf.push_back("a");
    line_buf.push_back(CH_NL);
    send_buf();
    line_buf.delete();
    repeat (KEY_LEN + 4) line_buf.push_back("b");
    line_buf.push_back(CH_EQ);
    line_buf.push_back(CH_NL);
    send_buf();
    wait_drained();
  endtask

  task automatic test_line_cut();
    line_buf.delete();
    line_buf.push_back("k");
    line_buf.push_back(CH_EQ);
    repeat (LINE_LEN - 3) line_buf.push_back("v");
    line_buf.push_back(CH_NL);
    line_buf.push_back("q");
    line_buf.push_back(CH_EQ);
    line_buf.push_back(CH_SQ);
    repeat (LINE_LEN + 5) line_buf.push_back("x");
    line_buf.push_back(CH_NL);
    repeat (LINE_LEN) line_buf.push_back(" ");
    line_buf.push_back(CH_NUL);
    send_buf();
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    tx_fast  = 1'b1;
    hold_req = 1'b1;
    repeat (3) begin
      build_line(1'b0);
      send_buf();
    end
    tx_fast = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_lines();
    int stop_at;
    int r;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) tx_fast = ~tx_fast;
      if ($urandom_range(0, 9) == 0) rx_fast = ~rx_fast;
      r = $urandom_range(0, 99);
      if (r < 75) build_line(1'b0);
      else if (r < 90) build_line(1'b1);
      else build_noise();
      send_buf();
    end
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_lines();
    test_values();
    test_early_outcomes();
    test_key_overflow();
    test_line_cut();
    test_output_backpressure();
    test_random_lines();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && token_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/kvlp_pkg.sv
rtl/kvlp_classify.sv
rtl/kvlp_step.sv
rtl/key_value_line_parser.sv
tb/sv/tb_key_value_line_parser.sv
